>>> rtl/rpn_pkg.sv
// Package: shared types, opcodes, status codes and sizes for the RPN stack calculator.
package rpn_pkg;

  localparam int StackDepth = 128;
  localparam int DepthW     = $clog2(StackDepth + 1);
  localparam int DivSteps   = 48;
  localparam int DivCntW    = $clog2(DivSteps + 1);

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_MUL     = 4'd3,
    OP_DIV     = 4'd4,
    OP_MOD     = 4'd5,
    OP_PEEK    = 4'd6,
    OP_DUP     = 4'd7,
    OP_SWAP    = 4'd8,
    OP_CLEAR   = 4'd9,
    OP_POPSHOW = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_ZDIV  = 3'd3,
    ST_SWAP  = 3'd4
  } status_t;

  // shift command common to every cell of the stack
  typedef enum logic [2:0] {
    SH_HOLD  = 3'd0,
    SH_PUSH  = 3'd1,
    SH_POP   = 3'd2,
    SH_SWAP  = 3'd3,
    SH_POP2  = 3'd4,
    SH_LOADT = 3'd5
  } shift_t;

  typedef struct packed {
    shift_t      cmd;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

>>> rtl/rpn_cell.sv
// One stack cell: holds an entry and shifts with its neighbours.
module rpn_cell (
  input  logic              clk,
  input  rpn_pkg::cell_ctl_t ctl,
  input  logic              is_top,
  input  logic [31:0]       above,
  input  logic [31:0]       above2,
  input  logic [31:0]       below,
  output logic [31:0]       value
);

  // cell 0 is the top of stack; deeper cells have higher indexes
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      rpn_pkg::SH_PUSH:  value <= is_top ? ctl.value : above;
      rpn_pkg::SH_POP:   value <= below;
      rpn_pkg::SH_POP2:  value <= is_top ? ctl.value : below;
      rpn_pkg::SH_SWAP:  value <= is_top ? below : above2;
      rpn_pkg::SH_LOADT: value <= is_top ? ctl.value : value;
      default:           value <= value;
    endcase
  end

endmodule

>>> rtl/rpn_divider.sv
// Iterative restoring divider, one quotient bit per cycle, on 48-bit magnitudes.
module rpn_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [47:0] quotient,
  output logic [31:0] remainder
);

  logic [rpn_pkg::DivCntW-1:0] count;
  logic [32:0] rem;
  logic [32:0] trial;

  assign trial     = {rem[31:0], quotient[47]} - {1'b0, divisor};
  assign remainder = rem[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= rpn_pkg::DivCntW'(rpn_pkg::DivSteps);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (trial[32]) begin
          rem      <= {rem[31:0], quotient[47]};
          quotient <= {quotient[46:0], 1'b0};
        end else begin
          rem      <= trial;
          quotient <= {quotient[46:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == rpn_pkg::DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/rpn_stack_calculator.sv
// Top level: RPN calculator with a shifting chain of stack cells.
// One transaction at a time. Push, peek, dup, swap, clear, popshow and add/sub
// go from the execute state to the output register; multiply passes through
// the multiply state (registered product, then shift and saturate); divide and
// modulus run the shared restoring divider at one quotient bit per cycle. The stack
// is a chain of 128 cells that all shift together, cell 0 holding the top.
// A result waits in the output register; the next transaction is taken once
// it is delivered.
module rpn_stack_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] op, [35:4] operand_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [31:0] shown_value, [32] shown_valid,
                                 // [35:33] status, [43:36] depth
);

  localparam int N = rpn_pkg::StackDepth;
  localparam int DW = rpn_pkg::DepthW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIVW  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [3:0]  op;
  logic [31:0] opnd;
  logic [DW-1:0] depth;
  logic [31:0] cells [N];
  rpn_pkg::cell_ctl_t ctl;

  logic [31:0]   res_value;
  logic          res_valid;
  rpn_pkg::status_t res_status;

  logic signed [31:0] a, b;
  logic under1, under2;
  logic signed [63:0] prod;
  logic signed [32:0] sum;
  logic signed [63:0] mulsh;
  logic [47:0] div_q;
  logic [31:0] div_r;
  logic div_busy, div_done, div_start;
  logic [47:0] div_n;
  logic [31:0] div_d;
  logic neg_q, neg_r;
  logic signed [15:0] ia, ib;
  logic [63:0] qs;
  logic signed [31:0] rem_s;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {4'd0, 8'(depth), res_status, res_valid, res_value};

  // operands seen from the top of stack
  assign under1 = (depth == '0);
  assign under2 = (depth < DW'(2));
  assign b  = under1 ? 32'sd0 : $signed(cells[0]);
  assign a  = under2 ? 32'sd0 : $signed(cells[1]);
  assign ia = 16'(b / 32'sd65536);
  assign ib = 16'(a / 32'sd65536);
  assign sum = (op == rpn_pkg::OP_ADD) ? (33'(a) + 33'(b)) : (33'(a) - 33'(b));
  assign mulsh = prod >>> 16;

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // on a swap only the two top cells exchange; deeper cells keep their value
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      rpn_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .is_top (g == 0),
        .above  ((g == 0) ? 32'd0 : cells[(g == 0) ? 0 : g - 1]),
        .above2 ((g < 2) ? cells[0] : cells[g]),
        .below  ((g == N - 1) ? 32'd0 : cells[(g == N - 1) ? g : g + 1]),
        .value  (cells[g])
      );
    end
  endgenerate

  rpn_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    ctl.cmd   = rpn_pkg::SH_HOLD;
    ctl.value = 32'd0;
    div_start = 1'b0;
    neg_q = a[31] ^ b[31];
    neg_r = ib[15];
    if (op == rpn_pkg::OP_DIV) begin
      div_n = a[31] ? 48'(-{a, 16'd0}) : {a, 16'd0};
      div_d = b[31] ? -b : b;
    end else begin
      neg_q = ib[15] ^ ia[15];
      div_n = 48'(ib[15] ? -32'(ib) : 32'(ib));
      div_d = ia[15] ? -32'(ia) : 32'(ia);
    end
    qs = 64'(div_q);
    if (neg_q) qs = -qs;
    rem_s = neg_r ? -div_r : div_r;
    if (state == S_EXEC) begin
      case (op)
        rpn_pkg::OP_PUSH: if (depth < DW'(N)) begin
          ctl.cmd = rpn_pkg::SH_PUSH; ctl.value = opnd;
        end
        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
          ctl.cmd = under2 ? rpn_pkg::SH_LOADT : rpn_pkg::SH_POP2;
          ctl.value = sat64(64'(sum));
        end
        rpn_pkg::OP_DUP: if (!under1 && depth < DW'(N)) begin
          ctl.cmd = rpn_pkg::SH_PUSH; ctl.value = cells[0];
        end
        rpn_pkg::OP_SWAP: if (!under2) ctl.cmd = rpn_pkg::SH_SWAP;
        rpn_pkg::OP_POPSHOW: if (!under1) ctl.cmd = rpn_pkg::SH_POP;
        rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
          if ((op == rpn_pkg::OP_DIV) ? (b == 0) : (ia == 0)) begin
            if (!under1) ctl.cmd = rpn_pkg::SH_POP;
          end else begin
            div_start = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state == S_MUL) begin
      ctl.cmd = under2 ? rpn_pkg::SH_LOADT : rpn_pkg::SH_POP2;
      ctl.value = sat64(mulsh);
    end else if (state == S_FIN) begin
      ctl.cmd = under2 ? rpn_pkg::SH_LOADT : rpn_pkg::SH_POP2;
      ctl.value = (op == rpn_pkg::OP_DIV) ? sat64(qs) : {rem_s[15:0], 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          op    <= s_tdata[3:0];
          opnd  <= s_tdata[35:4];
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_value  <= 32'd0;
          res_valid  <= 1'b0;
          res_status <= rpn_pkg::ST_OK;
          state      <= S_OUT;
          case (op)
            rpn_pkg::OP_PUSH, rpn_pkg::OP_DUP: begin
              if (op == rpn_pkg::OP_DUP && under1) res_status <= rpn_pkg::ST_UNDER;
              else if (depth < DW'(N)) depth <= depth + 1'b1;
              else res_status <= rpn_pkg::ST_FULL;
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
              depth <= under2 ? DW'(1) : depth - 1'b1;
              if (under2) res_status <= rpn_pkg::ST_UNDER;
            end
            rpn_pkg::OP_MUL: begin
              prod  <= 64'(a) * 64'(b);
              state <= S_MUL;
            end
            rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
              if (div_start) state <= S_DIVW;
              else begin
                if (!under1) depth <= depth - 1'b1;
                res_status <= under1 ? rpn_pkg::ST_UNDER : rpn_pkg::ST_ZDIV;
              end
            end
            rpn_pkg::OP_PEEK: begin
              if (under1) res_status <= rpn_pkg::ST_UNDER;
              else begin res_value <= cells[0]; res_valid <= 1'b1; end
            end
            rpn_pkg::OP_SWAP: if (under2) res_status <= rpn_pkg::ST_SWAP;
            rpn_pkg::OP_CLEAR: depth <= '0;
            rpn_pkg::OP_POPSHOW: begin
              if (under1) res_status <= rpn_pkg::ST_UNDER;
              else begin
                res_value <= cells[0]; res_valid <= 1'b1; depth <= depth - 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_MUL, S_FIN: begin
          depth <= under2 ? DW'(1) : depth - 1'b1;
          if (under2) res_status <= rpn_pkg::ST_UNDER;
          state <= S_OUT;
        end
        S_DIVW: if (div_done) state <= S_FIN;
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(N)) else $error("stack depth beyond capacity");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output open together");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIVW)) else $error("divider start outside divide wait");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVW) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");
  a_shown_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_valid) |-> (res_status == rpn_pkg::ST_OK))
    else $error("shown value with error status");
`endif

endmodule

>>> tb/sv/rpn_stack_calculator_checker.sv
// Checker: predicts each calculator result from accepted input transactions and compares.
module rpn_stack_calculator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          shown_count,
  output int          fault_count
);

  typedef struct packed {
    logic [31:0]      shown;
    logic             shown_ok;
    rpn_pkg::status_t status;
    logic [7:0]       depth;
  } calc_result_t;

  logic signed [31:0] stk [rpn_pkg::StackDepth];
  int unsigned        sp;
  calc_result_t       expected_q [$];

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] take(inout bit under);
    if (sp > 0) begin
      sp--;
      return stk[sp];
    end
    under = 1;
    return 0;
  endfunction

  function automatic bit put(input logic signed [31:0] v);
    if (sp < rpn_pkg::StackDepth) begin
      stk[sp] = v;
      sp++;
      return 1;
    end
    return 0;
  endfunction

  function automatic calc_result_t compute(input logic [3:0] op, input logic signed [31:0] x);
    calc_result_t r;
    logic signed [31:0] a, b, ia, ib;
    logic signed [63:0] p;
    bit under;
    bit ok;
    r = '0;
    r.status = rpn_pkg::ST_OK;
    under = 0;
    case (op)
      rpn_pkg::OP_PUSH: if (!put(x)) r.status = rpn_pkg::ST_FULL;
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
        b = take(under);
        a = take(under);
        if (op == rpn_pkg::OP_ADD) p = 64'(a) + 64'(b);
        else if (op == rpn_pkg::OP_SUB) p = 64'(a) - 64'(b);
        else p = (64'(a) * 64'(b)) >>> 16;
        ok = put(clamp32(p));
        if (under) r.status = rpn_pkg::ST_UNDER;
      end
      rpn_pkg::OP_DIV: begin
        b = take(under);
        if (b == 0) r.status = under ? rpn_pkg::ST_UNDER : rpn_pkg::ST_ZDIV;
        else begin
          a = take(under);
          p = (64'(a) * 64'sd65536) / 64'(b);
          ok = put(clamp32(p));
          if (under) r.status = rpn_pkg::ST_UNDER;
        end
      end
      rpn_pkg::OP_MOD: begin
        b = take(under);
        ib = b / 32'sd65536;
        if (ib == 0) r.status = under ? rpn_pkg::ST_UNDER : rpn_pkg::ST_ZDIV;
        else begin
          a = take(under);
          ia = a / 32'sd65536;
          p = 64'(ia % ib) * 64'sd65536;
          ok = put(clamp32(p));
          if (under) r.status = rpn_pkg::ST_UNDER;
        end
      end
      rpn_pkg::OP_PEEK: begin
        if (sp > 0) begin
          r.shown = stk[sp-1];
          r.shown_ok = 1;
        end else r.status = rpn_pkg::ST_UNDER;
      end
      rpn_pkg::OP_DUP: begin
        if (sp > 0) begin
          if (!put(stk[sp-1])) r.status = rpn_pkg::ST_FULL;
        end else r.status = rpn_pkg::ST_UNDER;
      end
      rpn_pkg::OP_SWAP: begin
        if (sp > 1) begin
          a = stk[sp-1];
          stk[sp-1] = stk[sp-2];
          stk[sp-2] = a;
        end else r.status = rpn_pkg::ST_SWAP;
      end
      rpn_pkg::OP_CLEAR: sp = 0;
      rpn_pkg::OP_POPSHOW: begin
        a = take(under);
        if (under) r.status = rpn_pkg::ST_UNDER;
        else begin
          r.shown = a;
          r.shown_ok = 1;
        end
      end
      default: ;
    endcase
    r.depth = sp[7:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    shown_count = 0;
    fault_count = 0;
    sp = 0;
  end

  always @(posedge clk) begin
    calc_result_t e, g;
    if (rst) begin
      sp = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        e = compute(s_tdata[3:0], s_tdata[35:4]);
        if (e.shown_ok) shown_count++;
        if (e.status != rpn_pkg::ST_OK) fault_count++;
        expected_q.push_back(e);
      end
      if (m_tvalid && m_tready) begin
        g = {m_tdata[31:0], m_tdata[32], rpn_pkg::status_t'(m_tdata[35:33]), m_tdata[43:36]};
        if (expected_q.size() == 0) report("unexpected transaction", m_tdata, '0);
        else begin
          e = expected_q.pop_front();
          if (g.shown != e.shown) report("shown_value", g.shown, e.shown);
          if (g.shown_ok != e.shown_ok) report("shown_valid", g.shown_ok, e.shown_ok);
          if (g.status != e.status) report("status", g.status, e.status);
          if (g.depth != e.depth) report("depth", g.depth, e.depth);
          if (m_tdata[47:44] != 0) report("padding", m_tdata, '0);
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

>>> tb/sv/rpn_stack_calculator_tb.sv
// Testbench top: drives opcodes into the calculator, paces the result side, reports the verdict.
module rpn_stack_calculator_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  int          fail_count, pending_count, shown_count, fault_count;
  int          sent = 0;
  bit          calm = 0;
  bit          hold_off = 0;

  rpn_stack_calculator dut (.*);

  rpn_stack_calculator_checker chk (.*);

  always #5 clk = ~clk;

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 65535)) - 32'sd32768;
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'h0000} +
                ($urandom_range(0, 12) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [3:0] op, input logic signed [31:0] v);
    s_tvalid <= 1;
    s_tdata <= {4'b0, v, op};
    do @(posedge clk); while (!s_tready);
    sent++;
    if (!calm && $urandom_range(0, 99) < 14) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(0, 99) >= 14);
  end

  task automatic random_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) send(rpn_pkg::OP_PUSH, pick_value());
    else if (k < 96) send(rpn_pkg::op_t'($urandom_range(1, 10)), $urandom);
    else send(4'($urandom_range(11, 15)), $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // empty-stack cases, then saturation, zero divisor, swap and an unknown opcode
    send(rpn_pkg::OP_POPSHOW, 0); send(rpn_pkg::OP_PEEK, 0);
    send(rpn_pkg::OP_DUP, 0); send(rpn_pkg::OP_SWAP, 0);
    send(rpn_pkg::OP_ADD, 0); send(rpn_pkg::OP_DIV, 0); send(rpn_pkg::OP_MOD, 0);
    send(rpn_pkg::OP_PUSH, 32'sh7fffffff); send(rpn_pkg::OP_PUSH, 32'sh7fffffff);
    send(rpn_pkg::OP_ADD, 0);
    send(rpn_pkg::OP_PUSH, 32'sh80000000); send(rpn_pkg::OP_MUL, 0);
    send(rpn_pkg::OP_PUSH, 32'sh00030000); send(rpn_pkg::OP_PUSH, 32'sh00008000);
    send(rpn_pkg::OP_MOD, 0);
    send(rpn_pkg::OP_PUSH, 0); send(rpn_pkg::OP_DIV, 0);
    send(rpn_pkg::OP_PUSH, 32'shfff90000); send(rpn_pkg::OP_SWAP, 0);
    send(rpn_pkg::OP_SUB, 0);
    send(rpn_pkg::OP_DUP, 0); send(rpn_pkg::OP_PEEK, 0); send(4'd15, 32'shffffffff);
    send(rpn_pkg::OP_POPSHOW, 0); send(rpn_pkg::OP_CLEAR, 0);
    // fill to overflow, with the result side held off at the start
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 135; i++)
          send(i % 3 ? rpn_pkg::OP_DUP : rpn_pkg::OP_PUSH, pick_value());
      end
    join
    send(rpn_pkg::OP_CLEAR, 0);
    calm = 1;
    for (int i = 0; i < 200; i++) random_op();
    calm = 0;
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 199) == 0) send(rpn_pkg::OP_CLEAR, 0);
      random_op();
    end
    s_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d opcodes sent, %0d values shown, %0d error statuses", sent, shown_count,
             fault_count);
    $display("covered empty stack, overflow under a long output stall, saturation and random mix");
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
